FILE: hw/rtl/dcs_pkg.sv
// Package for the delimited column selector: request types, register map and constants.
package dcs_pkg;

    // Default number of selectable columns
    localparam int MAX_COLUMNS_DEFAULT = 64;

    // Byte values
    localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
    localparam logic [7:0] DELIM_DEFAULT = 8'd44;

    // Register map: 64-bit registers at 8-byte spacing
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam int MASK_W  = 64;

    // Register index, taken from paddr[3]
    typedef enum logic {
        REG_COLUMN_MASK = 1'b0,
        REG_DELIMITER   = 1'b1
    } dcs_reg_idx_t;

    // Input request: one byte of text
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } dcs_in_t;

    // Output request: one byte of projected text
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } dcs_out_t;

endpackage

FILE: hw/rtl/delimited_column_selector.sv
// Delimited column selector: keeps the selected columns of each text line.
//
// Usage: text bytes enter on the in_ channel (valid/ready), one request per
// byte, with end_of_stream on the final byte. Projected bytes leave on the
// out_ channel (valid/ready); last_of_run marks the final output of the
// input byte that caused it. column_mask and delimiter are written over the
// APB port (mask at 0x0, delimiter at 0x8) while the block is idle.
// Path: an input byte is held in the input register, its results are formed on
// the way into the result register, and they leave on out_ from there.
// Throughput: one byte per cycle while out_ready stays high and each byte
// yields at most one output. A byte that yields two outputs (delimiter or
// data followed by the closing newline at end of stream) holds the two-entry
// result register until both have drained, as the output port drains one
// byte per cycle.
// Reset: column_mask clears, delimiter returns to ',', the line state
// returns to the start of a stream and both registers empty.
// Stall: while out_ready is low a filled result register holds; the input
// register still takes one more byte if it is empty, then in_ready drops.
module delimited_column_selector #(
    parameter int MAX_COLUMNS = dcs_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Byte input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dcs_pkg::dcs_in_t              in_data,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output dcs_pkg::dcs_out_t             out_data,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcs_pkg::PADDR_W-1:0]   paddr,
    input  logic [dcs_pkg::PDATA_W-1:0]   pwdata,
    output logic [dcs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int COL_W = $clog2(MAX_COLUMNS + 2);
    localparam int IDX_W = $clog2(dcs_pkg::MASK_W);
    localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMNS);

    // Configuration registers
    logic [dcs_pkg::MASK_W-1:0] column_mask_reg;
    logic [7:0]                 delimiter_reg;
    dcs_pkg::dcs_reg_idx_t      reg_idx;
    logic                       cfg_write;

    // Line state
    logic [COL_W-1:0] column_number_reg, column_number_next;
    logic             field_kept_reg, field_kept_next;
    logic             line_start_reg, line_start_next;
    logic             stopped_reg, stopped_next;

    // Input register
    logic             stage_valid_reg;
    dcs_pkg::dcs_in_t stage_data_reg;
    logic             advance;

    // Result register: up to two bytes
    logic [1:0] res_count_reg, res_count_next;
    logic [7:0] res_byte0_reg, res_byte0_next;
    logic [7:0] res_byte1_reg, res_byte1_next;
    logic       out_fire;

    // Results of the current byte
    logic [1:0] emit_count;
    logic [7:0] emit_byte0;
    logic [7:0] emit_byte1;

    // Column selection lookup
    function automatic logic col_selected(input logic [COL_W-1:0] col,
                                          input logic [dcs_pkg::MASK_W-1:0] mask);
        logic [COL_W-1:0] cm1;
        logic [IDX_W-1:0] idx;
        cm1 = col - COL_ONE;
        idx = IDX_W'(cm1);
        col_selected = (col >= COL_ONE) && (col <= COL_MAX) && mask[idx];
    endfunction

    // APB configuration port
    assign pready    = 1'b1;
    assign reg_idx   = dcs_pkg::dcs_reg_idx_t'(paddr[3]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            dcs_pkg::REG_COLUMN_MASK: prdata = column_mask_reg;
            dcs_pkg::REG_DELIMITER:   prdata = {{(dcs_pkg::PDATA_W-8){1'b0}}, delimiter_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_mask_reg <= '0;
            delimiter_reg   <= dcs_pkg::DELIM_DEFAULT;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                dcs_pkg::REG_COLUMN_MASK: column_mask_reg <= pwdata;
                dcs_pkg::REG_DELIMITER:   delimiter_reg   <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    // Handshakes
    assign out_valid = (res_count_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    assign advance   = stage_valid_reg &&
                       ((res_count_reg == 2'd0) || ((res_count_reg == 2'd1) && out_ready));
    assign in_ready  = !stage_valid_reg || advance;

    assign out_data.out_byte    = res_byte0_reg;
    assign out_data.last_of_run = (res_count_reg == 2'd1);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            stage_data_reg <= in_data;
    end

    // Per-byte field logic
    always_comb
    begin
        logic [7:0] b;
        logic       eos;
        logic       e0;
        logic [7:0] d0;
        logic       nl_close;
        b   = stage_data_reg.data_byte;
        eos = stage_data_reg.end_of_stream;
        e0  = 1'b0;
        d0  = b;
        column_number_next = column_number_reg;
        field_kept_next    = field_kept_reg;
        line_start_next    = line_start_reg;
        stopped_next       = stopped_reg;

        if (!stopped_reg)
        begin
            if (line_start_reg && (b == dcs_pkg::NEWLINE_BYTE))
                stopped_next = 1'b1;
            else
            begin
                if (line_start_reg)
                begin
                    line_start_next    = 1'b0;
                    column_number_next = COL_ONE;
                    field_kept_next    = col_selected(COL_ONE, column_mask_reg);
                end
                priority if (b == dcs_pkg::NEWLINE_BYTE)
                begin
                    e0 = field_kept_next;
                    d0 = dcs_pkg::NEWLINE_BYTE;
                    line_start_next    = 1'b1;
                    field_kept_next    = 1'b0;
                    column_number_next = COL_ONE;
                end
                else if (b == delimiter_reg)
                begin
                    if (column_number_next <= COL_MAX)
                        column_number_next = column_number_next + COL_ONE;
                    if (col_selected(column_number_next, column_mask_reg))
                    begin
                        e0 = field_kept_next;
                        d0 = delimiter_reg;
                        field_kept_next = 1'b1;
                    end
                end
                else
                begin
                    e0 = col_selected(column_number_next, column_mask_reg);
                end
            end
        end

        // End of stream closes an open kept line and restarts the state
        nl_close = eos && !stopped_next && !line_start_next && field_kept_next;
        if (eos)
        begin
            column_number_next = COL_ONE;
            field_kept_next    = 1'b0;
            line_start_next    = 1'b1;
            stopped_next       = 1'b0;
        end

        emit_byte1 = dcs_pkg::NEWLINE_BYTE;
        if (e0)
        begin
            emit_byte0 = d0;
            emit_count = nl_close ? 2'd2 : 2'd1;
        end
        else
        begin
            emit_byte0 = dcs_pkg::NEWLINE_BYTE;
            emit_count = nl_close ? 2'd1 : 2'd0;
        end
    end

    // Line state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_number_reg <= COL_ONE;
            field_kept_reg    <= 1'b0;
            line_start_reg    <= 1'b1;
            stopped_reg       <= 1'b0;
        end
        else if (advance)
        begin
            column_number_reg <= column_number_next;
            field_kept_reg    <= field_kept_next;
            line_start_reg    <= line_start_next;
            stopped_reg       <= stopped_next;
        end
    end

    // Result register load and drain
    always_comb
    begin
        res_count_next = res_count_reg;
        res_byte0_next = res_byte0_reg;
        res_byte1_next = res_byte1_reg;
        if (advance)
        begin
            res_count_next = emit_count;
            res_byte0_next = emit_byte0;
            res_byte1_next = emit_byte1;
        end
        else if (out_fire)
        begin
            res_count_next = res_count_reg - 2'd1;
            res_byte0_next = res_byte1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_count_reg <= 2'd0;
        else
            res_count_reg <= res_count_next;
    end

    always_ff @(posedge clk)
    begin
        res_byte0_reg <= res_byte0_next;
        res_byte1_reg <= res_byte1_next;
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg != 2'd3)
        else $error("result count out of range");

    a_col_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (column_number_reg >= COL_ONE) && (column_number_reg <= COL_MAX + COL_ONE))
        else $error("column number out of range");

    a_second_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && (res_count_reg == 2'd2)) |=> (out_valid && out_data.last_of_run))
        else $error("second result lost");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count_reg == 2'd0) |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

FILE: dv/column_selector_checker.sv
`timescale 1ns / 1ps
// Checker for the delimited column selector: predicts projected bytes and compares them.
module column_selector_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  dcs_pkg::dcs_in_t              in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  dcs_pkg::dcs_out_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [dcs_pkg::PADDR_W-1:0]   paddr,
    input  logic [dcs_pkg::PDATA_W-1:0]   pwdata,
    output int                            fail_count,
    output int                            pending
);

    localparam int MAX_COLS = dcs_pkg::MAX_COLUMNS_DEFAULT;

    // Shadow registers and line state
    logic [dcs_pkg::MASK_W-1:0] mask_reg    = '0;
    logic [7:0]                 delim_reg   = dcs_pkg::DELIM_DEFAULT;
    logic [6:0]                 col_num     = 7'd1;
    logic                       kept        = 1'b0;
    logic                       at_line_top = 1'b1;
    logic                       halted      = 1'b0;

    // Bytes produced by the request being predicted
    logic [7:0]        run_buf [2];
    int                run_len     = 0;

    dcs_pkg::dcs_out_t expected_bytes [$];
    int                mismatches  = 0;
    int                pending_n   = 0;

    assign fail_count = mismatches;
    assign pending    = pending_n;

    function automatic logic column_on(input logic [6:0] col);
        if (col < 7'd1 || int'(col) > MAX_COLS)
            return 1'b0;
        return mask_reg[6'(col - 7'd1)];
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        run_buf[run_len] = b;
        run_len++;
    endfunction

    function automatic void restart_stream();
        col_num     = 7'd1;
        kept        = 1'b0;
        at_line_top = 1'b1;
        halted      = 1'b0;
    endfunction

    // Work out the projected bytes of one input request and queue them
    function automatic void project_byte(input dcs_pkg::dcs_in_t req);
        logic [7:0]        b;
        dcs_pkg::dcs_out_t res;
        b = req.data_byte;
        run_len = 0;
        if (!halted) begin
            if (at_line_top && b == dcs_pkg::NEWLINE_BYTE) begin
                halted = 1'b1;
            end else begin
                if (at_line_top) begin
                    at_line_top = 1'b0;
                    col_num     = 7'd1;
                    kept        = column_on(7'd1);
                end
                if (b == dcs_pkg::NEWLINE_BYTE) begin
                    if (kept)
                        add_byte(dcs_pkg::NEWLINE_BYTE);
                    at_line_top = 1'b1;
                    kept        = 1'b0;
                    col_num     = 7'd1;
                end else if (b == delim_reg) begin
                    // counter stops one past the last selectable column
                    if (int'(col_num) <= MAX_COLS)
                        col_num = col_num + 7'd1;
                    if (column_on(col_num)) begin
                        if (kept)
                            add_byte(delim_reg);
                        kept = 1'b1;
                    end
                end else if (column_on(col_num)) begin
                    add_byte(b);
                end
            end
        end
        if (req.end_of_stream) begin
            // an open line that kept a field is closed at end of stream
            if (!halted && !at_line_top && kept)
                add_byte(dcs_pkg::NEWLINE_BYTE);
            restart_stream();
        end
        for (int i = 0; i < run_len; i++) begin
            res.out_byte    = run_buf[i];
            res.last_of_run = (i == run_len - 1);
            expected_bytes.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < 100)
            $display("%0t: mismatch on %s: got %02h, expected %02h", $realtime, what,
                     got, want);
        mismatches++;
    endtask

    // Watch the channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        dcs_pkg::dcs_out_t want;
        if (!rst_n) begin
            mask_reg  = '0;
            delim_reg = dcs_pkg::DELIM_DEFAULT;
            restart_stream();
            expected_bytes.delete();
            pending_n = 0;
        end else begin
            if (in_valid && in_ready)
                project_byte(in_data);
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected request", out_data.out_byte, 8'h00);
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", out_data.out_byte, want.out_byte);
                    if (out_data.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 8'(out_data.last_of_run),
                                        8'(want.last_of_run));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (dcs_pkg::dcs_reg_idx_t'(paddr[3]))
                    dcs_pkg::REG_COLUMN_MASK: mask_reg  = pwdata[dcs_pkg::MASK_W-1:0];
                    dcs_pkg::REG_DELIMITER:   delim_reg = pwdata[7:0];
                    default: ;
                endcase
            end
            pending_n = expected_bytes.size();
        end
    end

endmodule

FILE: dv/tb_delimited_column_selector.sv
`timescale 1ns / 1ps
// Testbench top for the delimited column selector: stimulus, register setup and verdict.
module tb_delimited_column_selector;

    localparam int TARGET_ITEMS = 1175;
    localparam int CYCLE_LIMIT  = 200000;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    dcs_pkg::dcs_in_t              in_data   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    dcs_pkg::dcs_out_t             out_data;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [dcs_pkg::PADDR_W-1:0]   paddr     = '0;
    logic [dcs_pkg::PDATA_W-1:0]   pwdata    = '0;
    logic [dcs_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    int                            fail_count;
    int                            pending;
    int                            item_count  = 0;
    int                            cycle_count = 0;
    logic [dcs_pkg::MASK_W-1:0]    cur_mask    = '0;
    logic [7:0]                    cur_delim   = dcs_pkg::DELIM_DEFAULT;
    logic [7:0]                    stream_q [$];

    delimited_column_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    column_selector_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure, with a calm stretch part way through
    always @(negedge clk)
    begin
        if (item_count >= 450 && item_count < 650)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 25);
    end

    // One input request; called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eos);
        dcs_pkg::dcs_in_t req;
        while (!(item_count >= 450 && item_count < 650) && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req.data_byte     = b;
        req.end_of_stream = eos;
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        item_count++;
        @(negedge clk);
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    // Drop valid and let the pipeline drain before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input dcs_pkg::dcs_reg_idx_t idx,
                             input logic [dcs_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dcs_pkg::PADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly plain text bytes; now and then anything at all
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 19) != 0 && (b == cur_delim || b == dcs_pkg::NEWLINE_BYTE))
            b = (cur_delim == 8'h5A) ? 8'h61 : 8'h5A;
        return b;
    endfunction

    // A stream of a few delimited lines, now and then a blank or very wide one
    task automatic build_stream();
        int   lines;
        int   nf;
        int   flen;
        logic wide_line;
        stream_q.delete();
        lines = $urandom_range(1, 5);
        for (int l = 0; l < lines; l++) begin
            if ($urandom_range(0, 19) == 0)
                stream_q.push_back(dcs_pkg::NEWLINE_BYTE);
            wide_line = ($urandom_range(0, 24) == 0);
            nf = wide_line ? $urandom_range(60, 72) : $urandom_range(1, 8);
            for (int f = 0; f < nf; f++) begin
                if (f > 0)
                    stream_q.push_back(cur_delim);
                flen = wide_line ? $urandom_range(0, 1) : $urandom_range(0, 6);
                for (int k = 0; k < flen; k++)
                    stream_q.push_back(text_byte());
            end
            // last line is left open half the time
            if (l < lines - 1 || $urandom_range(0, 1) == 1)
                stream_q.push_back(dcs_pkg::NEWLINE_BYTE);
        end
        if (stream_q.size() == 0)
            stream_q.push_back(text_byte());
    endtask

    initial
    begin
        int phase;
        int phase_end;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: nothing selected, comma delimiter
        stream_q = '{8'h61, dcs_pkg::DELIM_DEFAULT, 8'h62, dcs_pkg::NEWLINE_BYTE};
        send_stream();
        wait_idle();

        // Directed: columns 1 and 3 kept, default delimiter
        cur_mask = 64'h5;
        apb_write(dcs_pkg::REG_COLUMN_MASK, cur_mask);
        // extreme bytes, empty kept field, open line closed at end of stream
        stream_q = '{8'hFF, dcs_pkg::DELIM_DEFAULT, 8'h00, dcs_pkg::DELIM_DEFAULT, 8'h7E,
                     dcs_pkg::NEWLINE_BYTE, dcs_pkg::DELIM_DEFAULT, 8'h62,
                     dcs_pkg::NEWLINE_BYTE, 8'h78};
        send_stream();
        // blank line halts output until end of stream
        stream_q = '{8'h61, dcs_pkg::NEWLINE_BYTE, dcs_pkg::NEWLINE_BYTE, 8'h7A,
                     dcs_pkg::DELIM_DEFAULT, 8'h71};
        send_stream();
        // blank line that is also the end of stream, then a one-byte stream
        send_byte(dcs_pkg::NEWLINE_BYTE, 1'b1);
        send_byte(8'h80, 1'b1);
        wait_idle();

        // Random phases, the first few at fixed extremes
        phase = 0;
        while (item_count < TARGET_ITEMS) begin
            case (phase)
                0: begin cur_mask = '1; cur_delim = 8'h00; end
                1: begin cur_mask = '0; cur_delim = 8'hFF; end
                2: begin cur_mask = {1'b1, 62'b0, 1'b1}; cur_delim = dcs_pkg::DELIM_DEFAULT; end
                3: begin cur_mask = {$urandom, $urandom}; cur_delim = dcs_pkg::NEWLINE_BYTE; end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: cur_mask = '1;
                        1: cur_mask = dcs_pkg::MASK_W'(1) << $urandom_range(0, 63);
                        2: cur_mask = dcs_pkg::MASK_W'($urandom_range(0, 255));
                        3: cur_mask = {1'b1, 63'($urandom)} | dcs_pkg::MASK_W'($urandom);
                        default: cur_mask = {$urandom, $urandom};
                    endcase
                    case ($urandom_range(0, 7))
                        0: cur_delim = 8'h00;
                        1: cur_delim = 8'hFF;
                        2: cur_delim = 8'h09;
                        3, 4: cur_delim = dcs_pkg::DELIM_DEFAULT;
                        default: cur_delim = 8'($urandom_range(0, 255));
                    endcase
                    if (cur_delim == dcs_pkg::NEWLINE_BYTE)
                        cur_delim = dcs_pkg::DELIM_DEFAULT;
                end
            endcase
            apb_write(dcs_pkg::REG_COLUMN_MASK, cur_mask);
            // upper bits of the delimiter write are ignored by the block
            apb_write(dcs_pkg::REG_DELIMITER, {$urandom, 24'($urandom), cur_delim});
            phase_end = item_count + ((phase == 1) ? 30 : $urandom_range(60, 200));
            while (item_count < phase_end && item_count < TARGET_ITEMS) begin
                build_stream();
                send_stream();
            end
            wait_idle();
            phase++;
        end

        // Drain and settle
        wait_idle();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/dcs_pkg.sv
hw/rtl/delimited_column_selector.sv
dv/column_selector_checker.sv
dv/tb_delimited_column_selector.sv
